// ===== rtl/smi_pkg.sv =====
// Shared types and constants for the sorted multiset store.
`default_nettype none

package smi_pkg;

  localparam int unsigned ValueW      = 32;
  localparam int unsigned KindW       = 2;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned FillOutW    = 5;
  localparam int unsigned CapacityDef = 16;

  // Operation codes carried by the kind field
  typedef enum logic [KindW-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_MISSING = 2'd2
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    load;
    logic    compare;
    logic    wr_insert;
    logic    wr_remove;
    logic    wr_clear;
    logic    set_status;
    status_e status;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             full;
    logic             found;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/smi_datapath.sv =====
// Datapath: row of compare-and-shift cells, fill count and result registers.
`default_nettype none

module smi_datapath
  import smi_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDef
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  wire  [KindW-1:0]     kind_i,
  input  wire  [ValueW-1:0]    value_i,
  output logic [StatusW-1:0]   status_o,
  output logic [FillOutW-1:0]  fill_count_o,
  output logic [ValueW-1:0]    smallest_o,
  output logic                 smallest_valid_o
);

  localparam int unsigned FillW = $clog2(Capacity + 1);
  localparam int unsigned WideW = (FillW > FillOutW) ? FillW : FillOutW;

  logic [KindW-1:0]  kind_q;
  logic [ValueW-1:0] value_q;
  logic [ValueW-1:0] val_q [Capacity];
  logic [Capacity-1:0] lt_q;
  logic [Capacity-1:0] eq_q;
  logic [FillW-1:0]  fill_q;
  status_e           status_q;
  logic [WideW-1:0]  fill_wide;

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      value_q <= value_i;
    end
  end

  // One cell per entry: compare against the item, then keep, shift or take it
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [ValueW-1:0] ins_d;
    logic [ValueW-1:0] rem_d;

    if (i == 0) begin : g_head
      assign ins_d = lt_q[i] ? val_q[i] : value_q;
    end else begin : g_body
      assign ins_d = lt_q[i] ? val_q[i] : (lt_q[i-1] ? value_q : val_q[i-1]);
    end

    if (i == Capacity - 1) begin : g_tail
      assign rem_d = val_q[i];
    end else begin : g_mid
      assign rem_d = lt_q[i] ? val_q[i] : val_q[i+1];
    end

    // Register the compare flags; only held entries take part
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lt_q[i] <= 1'b0;
        eq_q[i] <= 1'b0;
      end else if (cmd_i.compare) begin
        lt_q[i] <= (fill_q > FillW'(i)) && ($signed(val_q[i]) < $signed(value_q));
        eq_q[i] <= (fill_q > FillW'(i)) && (val_q[i] == value_q);
      end
    end

    // Update the entry
    always_ff @(posedge clk_i) begin
      if (cmd_i.wr_insert) begin
        val_q[i] <= ins_d;
      end else if (cmd_i.wr_remove) begin
        val_q[i] <= rem_d;
      end
    end
  end

  // Track the fill count and the result status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      status_q <= STATUS_OK;
    end else begin
      if (cmd_i.wr_clear) begin
        fill_q <= '0;
      end else if (cmd_i.wr_insert) begin
        fill_q <= fill_q + FillW'(1);
      end else if (cmd_i.wr_remove) begin
        fill_q <= fill_q - FillW'(1);
      end
      if (cmd_i.set_status) begin
        status_q <= cmd_i.status;
      end
    end
  end

  // Report to the controller; equal entries sit right after the smaller ones
  assign sts_o.kind  = kind_q;
  assign sts_o.full  = (fill_q >= FillW'(Capacity));
  assign sts_o.found = |eq_q;

  // Drive the result fields from the held state
  assign fill_wide        = WideW'(fill_q);
  assign status_o         = status_q;
  assign fill_count_o     = fill_wide[FillOutW-1:0];
  assign smallest_valid_o = (fill_q != '0);
  assign smallest_o       = (fill_q != '0) ? val_q[0] : '0;

endmodule

`default_nettype wire

// ===== rtl/smi_ctrl.sv =====
// Controller: sequences load, compare, update and result handoff per item.
`default_nettype none

module smi_ctrl
  import smi_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  wire  out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_CMP;
      ST_CMP:  state_d = ST_UPD;
      ST_UPD:  state_d = ST_RESP;
      ST_RESP: if (!out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Issue datapath commands
  always_comb begin
    cmd_o = '0;
    cmd_o.status = STATUS_OK;
    case (state_q)
      ST_IDLE: cmd_o.load = in_valid_i;
      ST_CMP:  cmd_o.compare = 1'b1;
      ST_UPD: begin
        cmd_o.set_status = 1'b1;
        case (sts_i.kind)
          KIND_INSERT: begin
            if (sts_i.full) begin
              cmd_o.status = STATUS_FULL;
            end else begin
              cmd_o.wr_insert = 1'b1;
            end
          end
          KIND_REMOVE: begin
            if (sts_i.found) begin
              cmd_o.wr_remove = 1'b1;
            end else begin
              cmd_o.status = STATUS_MISSING;
            end
          end
          KIND_CLEAR: cmd_o.wr_clear = 1'b1;
          default:    cmd_o.status = STATUS_OK;
        endcase
      end
      default: cmd_o.load = 1'b0;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_RESP);

endmodule

`default_nettype wire

// ===== rtl/sorted_multiset_insert_remove.sv =====
// Top level of the sorted multiset store.
//
//   channel | direction | handshake               | fields
//   --------+-----------+-------------------------+-----------------------------------
//   in      | input     | in_valid_i / in_stall_o | kind_i, value_i
//   out     | output    | out_valid_o/out_stall_i | status_o, fill_count_o,
//           |           |                         | smallest_o, smallest_valid_o
//
// The result of an item is held while the output is stalled; the next item is taken
// the cycle after the result leaves, so the store takes no new item while one is in
// flight. An item passes through the load, compare and update steps of the cell row,
// each registered, before its result is valid.
// Reset empties the store; entry contents are not cleared and are never read.
`default_nettype none

module sorted_multiset_insert_remove
  import smi_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDef
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire  [KindW-1:0]     kind_i,
  input  wire  [ValueW-1:0]    value_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic [StatusW-1:0]   status_o,
  output logic [FillOutW-1:0]  fill_count_o,
  output logic [ValueW-1:0]    smallest_o,
  output logic                 smallest_valid_o
);

  cmd_t cmd;
  sts_t sts;

  smi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  smi_datapath #(
    .Capacity (Capacity)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .kind_i           (kind_i),
    .value_i          (value_i),
    .status_o         (status_o),
    .fill_count_o     (fill_count_o),
    .smallest_o       (smallest_o),
    .smallest_valid_o (smallest_valid_o)
  );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the sorted multiset store: driver, monitor and predictor.
`timescale 1ns / 100ps

module testbench;
  import smi_pkg::*;

  localparam int unsigned Cap        = CapacityDef;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned RandomOps  = 1950;
  localparam logic [KindW-1:0] KindUnused = 2'd3;

  // One operation for the store, with the sender's wait after it
  typedef struct {
    logic [KindW-1:0]         kind;
    logic signed [ValueW-1:0] value;
    int unsigned              gap;
    bit                       drain;
  } store_op_t;

  // What the store reports after one operation
  typedef struct {
    status_e                  status;
    logic [FillOutW-1:0]      fill;
    logic signed [ValueW-1:0] smallest;
    logic                     smallest_valid;
  } store_view_t;

  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;
  logic                 in_valid_i       = 1'b0;
  logic                 in_stall_o;
  logic [KindW-1:0]     kind_i           = KIND_INSERT;
  logic [ValueW-1:0]    value_i          = '0;
  logic                 out_valid_o;
  logic                 out_stall_i      = 1'b0;
  logic [StatusW-1:0]   status_o;
  logic [FillOutW-1:0]  fill_count_o;
  logic [ValueW-1:0]    smallest_o;
  logic                 smallest_valid_o;

  // Shadow copy of the store contents
  logic signed [ValueW-1:0] shadow_vals [Cap];
  int unsigned              shadow_fill = 0;

  store_op_t   op_queue [$];
  store_view_t awaited_views [$];
  store_op_t   next_op;
  store_view_t want;

  int unsigned ops_sent      = 0;
  int unsigned ops_taken     = 0;
  int unsigned views_seen    = 0;
  int unsigned views_paced   = 0;
  int unsigned send_hold     = 0;
  int unsigned stall_left    = 0;
  int unsigned cycle_cnt     = 0;
  bit          failed        = 1'b0;

  sorted_multiset_insert_remove u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .fill_count_o     (fill_count_o),
    .smallest_o       (smallest_o),
    .smallest_valid_o (smallest_valid_o)
  );

  always #10 clk_i = ~clk_i;

  // Apply one operation to the shadow store and return the expected report
  function automatic store_view_t apply_to_store(logic [KindW-1:0] kind,
                                                 logic signed [ValueW-1:0] val);
    store_view_t v;
    int unsigned pos;
    int unsigned i;
    v.status = STATUS_OK;
    pos = 0;
    case (kind)
      KIND_INSERT: begin
        if (shadow_fill >= Cap) begin
          v.status = STATUS_FULL;
        end else begin
          while (pos < shadow_fill && shadow_vals[pos] < val) pos++;
          for (i = shadow_fill; i > pos; i--) shadow_vals[i] = shadow_vals[i-1];
          shadow_vals[pos] = val;
          shadow_fill++;
        end
      end
      KIND_REMOVE: begin
        while (pos < shadow_fill && shadow_vals[pos] != val) pos++;
        if (pos >= shadow_fill) begin
          v.status = STATUS_MISSING;
        end else begin
          for (i = pos; i + 1 < shadow_fill; i++) shadow_vals[i] = shadow_vals[i+1];
          shadow_fill--;
        end
      end
      KIND_CLEAR: begin
        shadow_fill = 0;
      end
      default: ;
    endcase
    v.fill           = shadow_fill[FillOutW-1:0];
    v.smallest_valid = (shadow_fill != 0);
    v.smallest       = (shadow_fill != 0) ? shadow_vals[0] : '0;
    return v;
  endfunction

  // Wait length for either side: often none, otherwise a random length
  function automatic int unsigned draw_wait();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
  endfunction

  // Values cluster on a small pool so that duplicates and remove hits are common
  function automatic logic signed [ValueW-1:0] pick_value();
    logic signed [ValueW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $signed($urandom_range(0, 6)) - 3;
      5: v = {1'b1, {(ValueW-1){1'b0}}};
      6: v = {1'b0, {(ValueW-1){1'b1}}};
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic queue_op(logic [KindW-1:0] kind, logic signed [ValueW-1:0] val,
                          int unsigned gap, bit drain);
    store_op_t op;
    op.kind  = kind;
    op.value = val;
    op.gap   = gap;
    op.drain = drain;
    op_queue.push_back(op);
  endtask

  // Drive the next item at the falling edge; hold it until taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || ops_taken == ops_sent)) begin
      if (send_hold != 0) begin
        send_hold--;
        in_valid_i <= 1'b0;
      end else if (op_queue.size() != 0 &&
                   (!op_queue[0].drain || awaited_views.size() == 0)) begin
        next_op = op_queue.pop_front();
        kind_i     <= next_op.kind;
        value_i    <= next_op.value;
        in_valid_i <= 1'b1;
        ops_sent++;
        send_hold = next_op.gap;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Stall the output for a fresh count after each taken result
  always @(negedge clk_i) begin
    if (views_seen != views_paced) begin
      views_paced = views_seen;
      stall_left  = ((views_seen / 250) % 3 == 1) ? 0 : draw_wait();
    end
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Check results first, then record newly taken items
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        views_seen++;
        if (awaited_views.size() == 0) begin
          $error("result with no item pending: status %0d fill %0d", status_o, fill_count_o);
          failed = 1'b1;
        end else begin
          want = awaited_views.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            failed = 1'b1;
          end
          if (fill_count_o !== want.fill) begin
            $error("fill_count: expected %0d, got %0d", want.fill, fill_count_o);
            failed = 1'b1;
          end
          if (smallest_o !== want.smallest) begin
            $error("smallest: expected %0d, got %0d", want.smallest, $signed(smallest_o));
            failed = 1'b1;
          end
          if (smallest_valid_o !== want.smallest_valid) begin
            $error("smallest_valid: expected %0d, got %0d",
                   want.smallest_valid, smallest_valid_o);
            failed = 1'b1;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        awaited_views.push_back(apply_to_store(kind_i, value_i));
        ops_taken++;
      end
    end
  end

  // Hold reset, then release it at a falling edge
  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Abort a hung run
  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Build the stimulus, then wait for the store to drain and report
  initial begin
    int unsigned roll;
    int unsigned ins_pct;
    bit          calm;
    logic [KindW-1:0] k;

    // Directed: empty remove, extremes, duplicates, absent value, unused kind
    queue_op(KIND_REMOVE, 0, 0, 1'b0);
    queue_op(KIND_INSERT, {1'b0, {(ValueW-1){1'b1}}}, 0, 1'b0);
    queue_op(KIND_INSERT, {1'b1, {(ValueW-1){1'b0}}}, 0, 1'b0);
    queue_op(KIND_INSERT, -1, 0, 1'b0);
    queue_op(KIND_INSERT, -1, 0, 1'b0);
    queue_op(KIND_REMOVE, -1, 3, 1'b0);
    queue_op(KIND_REMOVE, 5, 0, 1'b0);
    queue_op(KindUnused, '1, 0, 1'b0);
    // Fill to capacity, overflow once, then take out the minimum and clear
    for (int n = 0; n < 13; n++) queue_op(KIND_INSERT, pick_value(), draw_wait(), 1'b0);
    queue_op(KIND_INSERT, 7, 0, 1'b0);
    queue_op(KIND_REMOVE, {1'b1, {(ValueW-1){1'b0}}}, 0, 1'b0);
    queue_op(KIND_CLEAR, '1, 0, 1'b0);

    // Random: phases that lean toward filling, emptying or neither
    ins_pct = 50;
    calm    = 1'b0;
    for (int n = 0; n < RandomOps; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 2))
          0: ins_pct = 75;
          1: ins_pct = 25;
          default: ins_pct = 50;
        endcase
        calm = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) k = KIND_CLEAR;
      else if (roll < 5) k = KindUnused;
      else if ($urandom_range(0, 99) < ins_pct) k = KIND_INSERT;
      else k = KIND_REMOVE;
      queue_op(k, pick_value(), calm ? 0 : draw_wait(), (n % 400 == 200) || (n == 0));
    end

    wait (rst_ni);
    wait (op_queue.size() == 0 && ops_taken == ops_sent);
    wait (awaited_views.size() == 0);
    repeat (20) @(posedge clk_i);
    if (!failed && awaited_views.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
